/* hw/rtl/atrr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// atrr_pkg
// Shared types for the aging table: operation codes, controller commands
// and the status group returned by the datapath.
// ----------------------------------------------------------------------------
package atrr_pkg;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_NEXT   = 2'd2,
        OP_TICK   = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_READ_IDX,
        CMD_SCAN_HIT,
        CMD_SCAN_ADV,
        CMD_APPEND,
        CMD_REFRESH,
        CMD_FULL,
        CMD_READ_NEXT,
        CMD_SHIFT_WR,
        CMD_COUNT_DEC,
        CMD_READ_RESULT,
        CMD_TAKE_RESULT,
        CMD_AGE_STEP,
        CMD_PUBLISH
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic match;
        logic idx_last;
        logic count_zero;
        logic count_full;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

/* hw/rtl/atrr_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// atrr_ctrl
// Sequencer for the aging table: scans, shifts and ages entries one at a
// time by issuing commands to the datapath.
// ----------------------------------------------------------------------------
module atrr_ctrl
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  wire atrr_pkg::status_t status,
    output atrr_pkg::cmd_t        cmd
);

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b0000000001,
        ST_DISPATCH = 10'b0000000010,
        ST_SCAN_RD  = 10'b0000000100,
        ST_SCAN_EV  = 10'b0000001000,
        ST_HIT      = 10'b0000010000,
        ST_MISS     = 10'b0000100000,
        ST_SHIFT_RD = 10'b0001000000,
        ST_SHIFT_WR = 10'b0010000000,
        ST_FETCH    = 10'b0100000000,
        ST_FINISH   = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   fetch_ev_reg;
    logic   fetch_ev_next;
    logic   age_reg;
    logic   age_next;

    always_comb
    begin
        state_next    = state_reg;
        fetch_ev_next = fetch_ev_reg;
        age_next      = age_reg;
        cmd           = atrr_pkg::CMD_NONE;
        req_ready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd        = atrr_pkg::CMD_LOAD;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (status.op == atrr_pkg::OP_TICK)
                begin
                    age_next   = 1'b1;
                    state_next = status.count_zero ? ST_FINISH : ST_SCAN_RD;
                end
                else
                begin
                    age_next   = 1'b0;
                    state_next = status.count_zero ? ST_MISS : ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                cmd        = atrr_pkg::CMD_READ_IDX;
                state_next = ST_SCAN_EV;
            end
            ST_SCAN_EV:
            begin
                if (age_reg)
                begin
                    cmd        = atrr_pkg::CMD_AGE_STEP;
                    state_next = status.idx_last ? ST_FINISH : ST_SCAN_RD;
                end
                else if (status.match)
                begin
                    cmd        = atrr_pkg::CMD_SCAN_HIT;
                    state_next = ST_HIT;
                end
                else
                begin
                    cmd        = atrr_pkg::CMD_SCAN_ADV;
                    state_next = status.idx_last ? ST_MISS : ST_SCAN_RD;
                end
            end
            ST_HIT:
            begin
                case (status.op)
                    atrr_pkg::OP_ADD:
                    begin
                        cmd        = atrr_pkg::CMD_REFRESH;
                        state_next = ST_FINISH;
                    end
                    atrr_pkg::OP_REMOVE:
                    begin
                        state_next = ST_SHIFT_RD;
                    end
                    default:
                    begin
                        fetch_ev_next = 1'b0;
                        state_next    = ST_FETCH;
                    end
                endcase
            end
            ST_MISS:
            begin
                case (status.op)
                    atrr_pkg::OP_ADD:
                    begin
                        cmd        = status.count_full ? atrr_pkg::CMD_FULL
                                                       : atrr_pkg::CMD_APPEND;
                        state_next = ST_FINISH;
                    end
                    atrr_pkg::OP_NEXT:
                    begin
                        fetch_ev_next = 1'b0;
                        state_next    = status.count_zero ? ST_FINISH : ST_FETCH;
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_SHIFT_RD:
            begin
                if (status.idx_last)
                begin
                    cmd        = atrr_pkg::CMD_COUNT_DEC;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd        = atrr_pkg::CMD_READ_NEXT;
                    state_next = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR:
            begin
                cmd        = atrr_pkg::CMD_SHIFT_WR;
                state_next = ST_SHIFT_RD;
            end
            ST_FETCH:
            begin
                if (fetch_ev_reg)
                begin
                    cmd        = atrr_pkg::CMD_TAKE_RESULT;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd           = atrr_pkg::CMD_READ_RESULT;
                    fetch_ev_next = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd        = atrr_pkg::CMD_PUBLISH;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fetch_ev_reg <= 1'b0;
            age_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fetch_ev_reg <= fetch_ev_next;
            age_reg      <= age_next;
        end
    end

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> (state_reg == ST_IDLE))
        else $error("ready outside idle");
    a_load_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == atrr_pkg::CMD_LOAD) |=> (state_reg == ST_DISPATCH))
        else $error("load not followed by dispatch");
    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == atrr_pkg::CMD_PUBLISH) |-> status.out_free)
        else $error("publish while output busy");
`endif

endmodule
`default_nettype wire

/* hw/rtl/atrr_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// atrr_datapath
// Entry memory, scan index, write pointer, live count, result flags and
// the output register of the aging table.
// ----------------------------------------------------------------------------
module atrr_datapath
#(
    parameter int DEPTH        = 16,
    parameter int ID_BITS      = 16,
    parameter int TIMEOUT_BITS = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [1:0]       operation,
    input  wire logic [15:0]      key_id,
    input  wire logic [15:0]      new_timeout,
    input  wire atrr_pkg::cmd_t   cmd,
    output atrr_pkg::status_t     status,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    output logic [15:0]           result_id,
    output logic                  found,
    output logic [8:0]            entry_count,
    output logic                  table_full,
    output logic                  was_empty,
    output logic [8:0]            expired_count
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [ID_BITS-1:0]      id_mem  [DEPTH];
    logic [TIMEOUT_BITS-1:0] tmo_mem [DEPTH];

    atrr_pkg::op_t           op_reg;
    logic [ID_BITS-1:0]      key_reg;
    logic [TIMEOUT_BITS-1:0] tmo_reg;
    logic [ID_BITS-1:0]      rd_id_reg;
    logic [TIMEOUT_BITS-1:0] rd_tmo_reg;
    logic [CNT_W-1:0]        count_reg,   count_next;
    logic [IDX_W-1:0]        idx_reg,     idx_next;
    logic [CNT_W-1:0]        wp_reg,      wp_next;
    logic                    found_reg,   found_next;
    logic                    full_reg,    full_next;
    logic                    empty_reg,   empty_next;
    logic [CNT_W-1:0]        expired_reg, expired_next;
    logic [ID_BITS-1:0]      result_reg,  result_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    logic [15:0]             out_id_reg;
    logic                    out_found_reg;
    logic [8:0]              out_count_reg;
    logic                    out_full_reg;
    logic                    out_empty_reg;
    logic [8:0]              out_expired_reg;

    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [ID_BITS-1:0]      wr_id;
    logic [TIMEOUT_BITS-1:0] wr_tmo;
    logic [CNT_W-1:0]        idx_ext;
    logic [IDX_W-1:0]        idx_inc;
    logic                    idx_last;
    logic                    keep;
    logic                    out_free;

    assign idx_ext  = CNT_W'(idx_reg);
    assign idx_inc  = IDX_W'(idx_ext + CNT_W'(1));
    assign idx_last = (idx_ext + CNT_W'(1)) >= count_reg;
    assign keep     = rd_tmo_reg > TIMEOUT_BITS'(1);
    assign out_free = !rsp_valid_reg || rsp_ready;

    assign status.op         = op_reg;
    assign status.match      = (rd_id_reg == key_reg);
    assign status.idx_last   = idx_last;
    assign status.count_zero = (count_reg == '0);
    assign status.count_full = (count_reg == CNT_W'(DEPTH));
    assign status.out_free   = out_free;

    always_comb
    begin
        count_next     = count_reg;
        idx_next       = idx_reg;
        wp_next        = wp_reg;
        found_next     = found_reg;
        full_next      = full_reg;
        empty_next     = empty_reg;
        expired_next   = expired_reg;
        result_next    = result_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rd_en          = 1'b0;
        rd_addr        = idx_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_id          = key_reg;
        wr_tmo         = tmo_reg;
        case (cmd)
            atrr_pkg::CMD_LOAD:
            begin
                idx_next     = '0;
                wp_next      = '0;
                found_next   = 1'b0;
                full_next    = 1'b0;
                empty_next   = (count_reg == '0);
                expired_next = '0;
                result_next  = '0;
            end
            atrr_pkg::CMD_READ_IDX:
            begin
                rd_en = 1'b1;
            end
            atrr_pkg::CMD_SCAN_HIT:
            begin
                found_next = 1'b1;
            end
            atrr_pkg::CMD_SCAN_ADV:
            begin
                idx_next = idx_inc;
            end
            atrr_pkg::CMD_APPEND:
            begin
                wr_en      = 1'b1;
                wr_addr    = IDX_W'(count_reg);
                count_next = count_reg + CNT_W'(1);
            end
            atrr_pkg::CMD_REFRESH:
            begin
                wr_en = 1'b1;
            end
            atrr_pkg::CMD_FULL:
            begin
                full_next = 1'b1;
            end
            atrr_pkg::CMD_READ_NEXT:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_inc;
            end
            atrr_pkg::CMD_SHIFT_WR:
            begin
                wr_en    = 1'b1;
                wr_id    = rd_id_reg;
                wr_tmo   = rd_tmo_reg;
                idx_next = idx_inc;
            end
            atrr_pkg::CMD_COUNT_DEC:
            begin
                count_next = count_reg - CNT_W'(1);
            end
            atrr_pkg::CMD_READ_RESULT:
            begin
                rd_en   = 1'b1;
                rd_addr = (found_reg && !idx_last) ? idx_inc : '0;
            end
            atrr_pkg::CMD_TAKE_RESULT:
            begin
                result_next = rd_id_reg;
            end
            atrr_pkg::CMD_AGE_STEP:
            begin
                idx_next = idx_inc;
                if (keep)
                begin
                    wr_en   = 1'b1;
                    wr_addr = IDX_W'(wp_reg);
                    wr_id   = rd_id_reg;
                    wr_tmo  = rd_tmo_reg - TIMEOUT_BITS'(1);
                    wp_next = wp_reg + CNT_W'(1);
                end
                else
                begin
                    expired_next = expired_reg + CNT_W'(1);
                end
                if (idx_last)
                begin
                    count_next = keep ? (wp_reg + CNT_W'(1)) : wp_reg;
                end
            end
            atrr_pkg::CMD_PUBLISH:
            begin
                rsp_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            id_mem[wr_addr]  <= wr_id;
            tmo_mem[wr_addr] <= wr_tmo;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_id_reg  <= id_mem[rd_addr];
            rd_tmo_reg <= tmo_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd == atrr_pkg::CMD_LOAD)
        begin
            op_reg  <= atrr_pkg::op_t'(operation);
            key_reg <= ID_BITS'(key_id);
            tmo_reg <= TIMEOUT_BITS'(new_timeout);
        end
        idx_reg     <= idx_next;
        wp_reg      <= wp_next;
        found_reg   <= found_next;
        full_reg    <= full_next;
        empty_reg   <= empty_next;
        expired_reg <= expired_next;
        result_reg  <= result_next;
        if (cmd == atrr_pkg::CMD_PUBLISH)
        begin
            out_id_reg      <= 16'(result_reg);
            out_found_reg   <= found_reg;
            out_count_reg   <= 9'(count_reg);
            out_full_reg    <= full_reg;
            out_empty_reg   <= empty_reg;
            out_expired_reg <= 9'(expired_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign result_id     = out_id_reg;
    assign found         = out_found_reg;
    assign entry_count   = out_count_reg;
    assign table_full    = out_full_reg;
    assign was_empty     = out_empty_reg;
    assign expired_count = out_expired_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("live count above depth");
    a_age_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == atrr_pkg::CMD_AGE_STEP) |-> (wp_reg <= idx_ext))
        else $error("aging write pointer ahead of read index");
    a_publish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == atrr_pkg::CMD_PUBLISH) |=> rsp_valid_reg)
        else $error("publish did not raise valid");
`endif

endmodule
`default_nettype wire

/* hw/rtl/aging_table_round_robin.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// aging_table_round_robin
// Bounded table of id/timeout pairs kept in insertion order, with add or
// refresh, remove, next-after and aging tick operations.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready) carries operation, key_id and
//   new_timeout; response channel (rsp_valid/rsp_ready) returns one item
//   per request with result_id, found, entry_count, table_full, was_empty
//   and expired_count.
//   Requests are handled one at a time. Entries sit in a single-port-write,
//   registered-read memory and are visited one at a time, each scan step
//   passing through a read state and an evaluate state. req_ready rises
//   with rsp_valid, so the next request can be accepted as soon as the
//   response is offered.
//   Reset empties the table at once (live count to zero); memory contents
//   are not cleared. A finished response waits in the output register while
//   the next request is accepted and processed; if the receiver stalls,
//   that request holds in its final state until the output register frees.
// ----------------------------------------------------------------------------
module aging_table_round_robin
#(
    parameter int DEPTH        = 16,
    parameter int ID_BITS      = 16,
    parameter int TIMEOUT_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire logic [1:0]  operation,
    input  wire logic [15:0] key_id,
    input  wire logic [15:0] new_timeout,
    output logic             rsp_valid,
    input  wire logic        rsp_ready,
    output logic [15:0]      result_id,
    output logic             found,
    output logic [8:0]       entry_count,
    output logic             table_full,
    output logic             was_empty,
    output logic [8:0]       expired_count
);

    atrr_pkg::cmd_t    cmd;
    atrr_pkg::status_t status;

    atrr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    atrr_datapath
    #(
        .DEPTH        (DEPTH),
        .ID_BITS      (ID_BITS),
        .TIMEOUT_BITS (TIMEOUT_BITS)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .operation     (operation),
        .key_id        (key_id),
        .new_timeout   (new_timeout),
        .cmd           (cmd),
        .status        (status),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .result_id     (result_id),
        .found         (found),
        .entry_count   (entry_count),
        .table_full    (table_full),
        .was_empty     (was_empty),
        .expired_count (expired_count)
    );

endmodule
`default_nettype wire
